/* rtl/hidrd_pkg.sv */
package hidrd_pkg;

  // sizes
  localparam int STACK_DEPTH       = 4;
  localparam int LOCAL_USAGE_DEPTH = 16;
  localparam int REPORT_ID_COUNT   = 256;
  localparam int FIELDS_PER_MAIN   = 63;

  localparam int SL_W      = $clog2(STACK_DEPTH + 1);
  localparam int SK_IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LU_W      = $clog2(LOCAL_USAGE_DEPTH + 1);
  localparam int LU_IDX_W  = (LOCAL_USAGE_DEPTH > 1) ? $clog2(LOCAL_USAGE_DEPTH) : 1;
  localparam int RID_IDX_W = (REPORT_ID_COUNT > 1) ? $clog2(REPORT_ID_COUNT) : 1;
  localparam int MADE_W    = $clog2(FIELDS_PER_MAIN + 1);

  localparam logic [19:0] CURSOR_MAX = 20'hFFFFF;
  localparam logic [7:0]  LONG_PREFIX = 8'hFE;
  localparam logic [15:0] PAGE_GD   = 16'h0001;
  localparam logic [15:0] PAGE_DIGI = 16'h000D;

  // item types
  localparam logic [1:0] TYPE_MAIN   = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL = 2'd1;
  localparam logic [1:0] TYPE_LOCAL  = 2'd2;

  // global tags
  localparam logic [3:0] G_PAGE   = 4'h0;
  localparam logic [3:0] G_LMIN   = 4'h1;
  localparam logic [3:0] G_LMAX   = 4'h2;
  localparam logic [3:0] G_RSIZE  = 4'h7;
  localparam logic [3:0] G_RID    = 4'h8;
  localparam logic [3:0] G_RCOUNT = 4'h9;
  localparam logic [3:0] G_PUSH   = 4'hA;
  localparam logic [3:0] G_POP    = 4'hB;

  // local tags
  localparam logic [3:0] L_USAGE = 4'h0;
  localparam logic [3:0] L_UMIN  = 4'h1;
  localparam logic [3:0] L_UMAX  = 4'h2;

  // main tags
  localparam logic [3:0] M_INPUT = 4'h8;

  // slot codes
  localparam logic [4:0] SLOT_X        = 5'd0;
  localparam logic [4:0] SLOT_Y        = 5'd1;
  localparam logic [4:0] SLOT_PRESSURE = 5'd2;
  localparam logic [4:0] SLOT_DISTANCE = 5'd3;
  localparam logic [4:0] SLOT_TILT_X   = 5'd4;
  localparam logic [4:0] SLOT_TILT_Y   = 5'd5;
  localparam logic [4:0] SLOT_ROTATION = 5'd6;
  localparam logic [4:0] SLOT_SLIDER   = 5'd7;
  localparam logic [4:0] SLOT_WHEEL    = 5'd8;
  localparam logic [4:0] SLOT_INRANGE  = 5'd9;
  localparam logic [4:0] SLOT_TIP      = 5'd10;
  localparam logic [4:0] SLOT_INVERT   = 5'd11;
  localparam logic [4:0] SLOT_BARREL   = 5'd12;
  localparam logic [4:0] SLOT_BARREL2  = 5'd13;
  localparam logic [4:0] SLOT_ERASER   = 5'd14;
  localparam logic [4:0] SLOT_SERIAL   = 5'd15;
  localparam logic [4:0] SLOT_NONE     = 5'd16;

  typedef enum logic [1:0] {
    PH_PREFIX, PH_PAYLOAD, PH_LONG_SIZE, PH_LONG_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_WALK, S_FLUSH, S_SUM
  } state_t;

  typedef struct packed {
    logic [15:0] page;
    logic [31:0] lmin;
    logic [32:0] lmax;
    logic [7:0]  rsize;
    logic [15:0] rcount;
    logic [7:0]  rid;
  } gregs_t;

  typedef struct packed {
    logic [7:0] desc_byte;
    logic       end_of_descriptor;
  } in_t;

  typedef struct packed {
    logic               record_kind;
    logic [7:0]         field_report_id;
    logic [15:0]        field_page;
    logic [15:0]        field_usage;
    logic [19:0]        bit_pos;
    logic [7:0]         field_width;
    logic signed [31:0] range_min;
    logic signed [32:0] range_max;
    logic [3:0]         slot_code;
    logic [5:0]         axes_mask;
    logic [4:0]         status_flags;
    logic               last_of_run;
  } out_t;

  // cursor memory write port
  typedef struct packed {
    logic                 en;
    logic [RID_IDX_W-1:0] addr;
    logic [19:0]          data;
  } cur_wr_t;

  function automatic logic [4:0] slot_of(input logic [15:0] page, input logic [15:0] usage);
    logic [4:0] s;
    s = SLOT_NONE;
    if (page == PAGE_GD) begin
      unique case (usage)
        16'h30:  s = SLOT_X;
        16'h31:  s = SLOT_Y;
        16'h32:  s = SLOT_DISTANCE;
        16'h38:  s = SLOT_WHEEL;
        default: s = SLOT_NONE;
      endcase
    end else if (page == PAGE_DIGI) begin
      unique case (usage)
        16'h30:  s = SLOT_PRESSURE;
        16'h31:  s = SLOT_SLIDER;
        16'h3D:  s = SLOT_TILT_X;
        16'h3E:  s = SLOT_TILT_Y;
        16'h41:  s = SLOT_ROTATION;
        16'h32:  s = SLOT_INRANGE;
        16'h42:  s = SLOT_TIP;
        16'h3C:  s = SLOT_INVERT;
        16'h44:  s = SLOT_BARREL;
        16'h5A:  s = SLOT_BARREL2;
        16'h45:  s = SLOT_ERASER;
        16'h5B:  s = SLOT_SERIAL;
        default: s = SLOT_NONE;
      endcase
    end
    return s;
  endfunction

  function automatic logic [5:0] axis_bit(input logic [4:0] slot);
    logic [5:0] a;
    unique case (slot)
      SLOT_PRESSURE:            a = 6'h01;
      SLOT_DISTANCE:            a = 6'h02;
      SLOT_TILT_X, SLOT_TILT_Y: a = 6'h04;
      SLOT_ROTATION:            a = 6'h08;
      SLOT_SLIDER:              a = 6'h10;
      SLOT_WHEEL:               a = 6'h20;
      default:                  a = 6'h00;
    endcase
    return a;
  endfunction

endpackage

/* rtl/hidrd_cursor_mem.sv */
module hidrd_cursor_mem import hidrd_pkg::*; (
  input  logic                 clk,
  input  cur_wr_t              wr,
  input  logic [RID_IDX_W-1:0] raddr,
  output logic [19:0]          rdata_r
);

  logic [19:0] mem [REPORT_ID_COUNT];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

/* rtl/hid_report_descriptor_parser_top.sv */
// HID report descriptor parser for pen tablets.
// Input channel: one descriptor byte per transaction (in_data.desc_byte),
// with in_data.end_of_descriptor marking the last byte. Output channel: one
// field record or end summary per transaction; last_of_run flags the last
// record a byte caused.
// Most bytes are taken directly. An Input main item with nonzero size and
// count goes through a cursor fetch (S_LOAD), a walk over its report count
// elements (S_WALK) and a hand-over of its last record (S_FLUSH); the walk
// is one pass over the count through the per-report-ID cursor memory
// (one read, one write). The end byte adds the summary (S_SUM), then a
// clearing pass over all 256 cursor memory entries during which no byte is
// taken. The same clearing pass runs after reset (rst_n low, synchronous),
// so no byte is taken until it is over.
// Results sit in an output register; while out_stall is high the record
// holds and the walk pauses when it has a further record to hand over.
// in_stall is high whenever the block is not waiting for a byte.
module hid_report_descriptor_parser_top import hidrd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [7:0]  prefix_r, prefix_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [8:0]  skip_r, skip_nxt;
  gregs_t      glob_r, glob_nxt;
  gregs_t      stack_mem [STACK_DEPTH];
  logic [SL_W-1:0] level_r, level_nxt;
  logic [31:0] ulist_mem [LOCAL_USAGE_DEPTH];
  logic [LU_W-1:0] ucnt_r, ucnt_nxt;
  logic [31:0] rlo_r, rlo_nxt, rhi_r, rhi_nxt;
  logic        rflag_r, rflag_nxt;
  logic [5:0]  axes_r, axes_nxt;
  logic        ids_r, ids_nxt, inv_r, inv_nxt, ser_r, ser_nxt;
  logic        digi_r, digi_nxt, ovf_r, ovf_nxt;
  logic        endp_r, endp_nxt;
  logic        const_r, const_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [MADE_W-1:0] made_r, made_nxt;
  logic [19:0] cur_r, cur_nxt;
  logic [RID_IDX_W-1:0] ci_r, ci_nxt, clr_r, clr_nxt;
  out_t        pend_r, pend_nxt;
  logic        pendv_r, pendv_nxt;
  logic        outv_r, outv_nxt;
  out_t        out_r, out_nxt;

  logic        stack_we, ulist_we;
  logic [31:0] ulist_wd;
  logic        accept, load_ok, soft_clr;
  logic        start_walk, walk_last, walk_adv, flush_done, sum_done, clr_last;
  logic [19:0] rd_q;
  logic [RID_IDX_W-1:0] raddr;
  cur_wr_t     cwr;

  // per-byte decode
  logic        do_exec;
  logic [7:0]  ex_pfx;
  logic [31:0] ex_v;
  logic [2:0]  ex_nb;
  logic [2:0]  total;
  logic [31:0] psig;
  logic [1:0]  ex_type;
  logic [3:0]  ex_tag;

  // walk datapath
  logic [31:0] ent;
  logic [LU_IDX_W-1:0] uidx;
  logic [32:0] rsum;
  logic [15:0] w_page, w_usage;
  logic [4:0]  w_slot;
  logic        w_hit, w_emit, w_block;
  logic [20:0] cur_sum;
  logic [19:0] cur_step;
  out_t        w_rec, sum_rec;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign load_ok  = !outv_r || !out_stall;
  assign out_valid = outv_r;
  assign out_data  = out_r;

  // cursor memory read address follows the current report id
  always_comb begin
    if (32'(glob_r.rid) >= 32'(REPORT_ID_COUNT)) begin
      raddr = RID_IDX_W'(REPORT_ID_COUNT - 1);
    end else begin
      raddr = glob_r.rid[RID_IDX_W-1:0];
    end
  end

  hidrd_cursor_mem u_cursor_mem (
    .clk     (clk),
    .wr      (cwr),
    .raddr   (raddr),
    .rdata_r (rd_q)
  );

  // payload sign extension
  always_comb begin
    psig = ex_v;
    if (ex_nb == 3'd1 && ex_v[7]) begin
      psig = ex_v | 32'hFFFFFF00;
    end else if (ex_nb == 3'd2 && ex_v[15]) begin
      psig = ex_v | 32'hFFFF0000;
    end
  end

  assign total = (prefix_r[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix_r[1:0]};
  assign ex_type = ex_pfx[3:2];
  assign ex_tag  = ex_pfx[7:4];

  // walk element: usage selection, slot lookup and cursor step
  always_comb begin
    if (ucnt_r == '0) begin
      uidx = '0;
    end else if (idx_r < 16'(ucnt_r)) begin
      uidx = idx_r[LU_IDX_W-1:0];
    end else begin
      uidx = LU_IDX_W'(ucnt_r - 1'b1);
    end
    ent  = ulist_mem[uidx];
    rsum = {1'b0, rlo_r} + {17'b0, idx_r};
    if (rsum > {1'b0, rhi_r}) begin
      rsum = {1'b0, rhi_r};
    end
    w_page  = glob_r.page;
    w_usage = '0;
    if (ucnt_r != '0) begin
      w_page  = ent[31:16];
      w_usage = ent[15:0];
    end else if (rflag_r) begin
      w_usage = rsum[15:0];
    end
    w_slot  = const_r ? SLOT_NONE : slot_of(w_page, w_usage);
    w_hit   = (w_slot != SLOT_NONE);
    w_emit  = w_hit && (32'(made_r) < 32'(FIELDS_PER_MAIN));
    w_block = w_emit && pendv_r && !load_ok;
    cur_sum = {1'b0, cur_r} + {13'b0, glob_r.rsize};
    cur_step = (cur_sum > {1'b0, CURSOR_MAX}) ? CURSOR_MAX : cur_sum[19:0];

    w_rec = '0;
    w_rec.field_report_id = glob_r.rid;
    w_rec.field_page      = w_page;
    w_rec.field_usage     = w_usage;
    w_rec.bit_pos         = cur_r;
    w_rec.field_width     = glob_r.rsize;
    w_rec.range_min       = glob_r.lmin;
    w_rec.range_max       = glob_r.lmax;
    w_rec.slot_code       = w_slot[3:0];

    sum_rec = '0;
    sum_rec.record_kind  = 1'b1;
    sum_rec.axes_mask    = axes_r;
    sum_rec.status_flags = {ovf_r, digi_r, ser_r, inv_r, ids_r};
    sum_rec.last_of_run  = 1'b1;
  end

  assign walk_adv   = (state_r == S_WALK) && !w_block;
  assign walk_last  = walk_adv && (idx_r == glob_r.rcount - 16'd1);
  assign flush_done = (state_r == S_FLUSH) && (!pendv_r || load_ok);
  assign sum_done   = (state_r == S_SUM) && load_ok;
  assign clr_last   = (state_r == S_CLEAR) && (clr_r == RID_IDX_W'(REPORT_ID_COUNT - 1));
  assign soft_clr   = sum_done;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (start_walk) begin
            state_nxt = S_LOAD;
          end else if (in_data.end_of_descriptor) begin
            state_nxt = S_SUM;
          end
        end
      end
      S_LOAD:  state_nxt = S_WALK;
      S_WALK:  if (walk_last) state_nxt = S_FLUSH;
      S_FLUSH: if (flush_done) state_nxt = endp_r ? S_SUM : S_IDLE;
      S_SUM:   if (sum_done) state_nxt = S_CLEAR;
      default: state_nxt = S_IDLE;
    endcase
  end

  // byte parsing, item execution, walk and output loading
  always_comb begin
    phase_nxt  = phase_r;
    prefix_nxt = prefix_r;
    accum_nxt  = accum_r;
    left_nxt   = left_r;
    skip_nxt   = skip_r;
    glob_nxt   = glob_r;
    level_nxt  = level_r;
    ucnt_nxt   = ucnt_r;
    rlo_nxt    = rlo_r;
    rhi_nxt    = rhi_r;
    rflag_nxt  = rflag_r;
    axes_nxt   = axes_r;
    ids_nxt    = ids_r;
    inv_nxt    = inv_r;
    ser_nxt    = ser_r;
    digi_nxt   = digi_r;
    ovf_nxt    = ovf_r;
    endp_nxt   = endp_r;
    const_nxt  = const_r;
    idx_nxt    = idx_r;
    made_nxt   = made_r;
    cur_nxt    = cur_r;
    ci_nxt     = ci_r;
    clr_nxt    = clr_r;
    pend_nxt   = pend_r;
    pendv_nxt  = pendv_r;
    outv_nxt   = outv_r && out_stall;
    out_nxt    = out_r;
    stack_we   = 1'b0;
    ulist_we   = 1'b0;
    ulist_wd   = '0;
    start_walk = 1'b0;
    do_exec    = 1'b0;
    ex_pfx     = '0;
    ex_v       = '0;
    ex_nb      = '0;
    cwr        = '0;

    // framing of short and long items
    if (accept) begin
      endp_nxt = in_data.end_of_descriptor;
      unique case (phase_r)
        PH_PREFIX: begin
          if (in_data.desc_byte == LONG_PREFIX) begin
            phase_nxt = PH_LONG_SIZE;
          end else if (in_data.desc_byte[1:0] == 2'd0) begin
            do_exec = 1'b1;
            ex_pfx  = in_data.desc_byte;
          end else begin
            prefix_nxt = in_data.desc_byte;
            accum_nxt  = '0;
            left_nxt   = (in_data.desc_byte[1:0] == 2'd3) ? 3'd4
                                                           : {1'b0, in_data.desc_byte[1:0]};
            phase_nxt  = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          accum_nxt = accum_r | ({24'b0, in_data.desc_byte} << {(total - left_r), 3'b000});
          left_nxt  = left_r - 3'd1;
          if (left_r == 3'd1) begin
            phase_nxt = PH_PREFIX;
            do_exec   = 1'b1;
            ex_pfx    = prefix_r;
            ex_v      = accum_nxt;
            ex_nb     = total;
          end
        end
        PH_LONG_SIZE: begin
          skip_nxt  = {1'b0, in_data.desc_byte} + 9'd1;
          phase_nxt = PH_LONG_SKIP;
        end
        default: begin
          skip_nxt = (skip_r != '0) ? skip_r - 9'd1 : skip_r;
          if (skip_nxt == '0) begin
            phase_nxt = PH_PREFIX;
          end
        end
      endcase
    end

    // item execution
    if (do_exec) begin
      unique case (ex_type)
        TYPE_GLOBAL: begin
          unique case (ex_tag)
            G_PAGE: begin
              glob_nxt.page = ex_v[15:0];
              if (ex_v[15:0] == PAGE_DIGI) digi_nxt = 1'b1;
            end
            G_LMIN: glob_nxt.lmin = psig;
            G_LMAX: glob_nxt.lmax = (!glob_r.lmin[31] && psig[31]) ? {1'b0, ex_v}
                                                                    : {psig[31], psig};
            G_RSIZE:  glob_nxt.rsize = (ex_v > 32'd255) ? 8'hFF : ex_v[7:0];
            G_RID: begin
              glob_nxt.rid = ex_v[7:0];
              ids_nxt = 1'b1;
            end
            G_RCOUNT: glob_nxt.rcount = (ex_v > 32'hFFFF) ? 16'hFFFF : ex_v[15:0];
            G_PUSH: begin
              if (32'(level_r) < 32'(STACK_DEPTH)) begin
                stack_we  = 1'b1;
                level_nxt = level_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            G_POP: begin
              if (level_r != '0) begin
                glob_nxt  = stack_mem[SK_IDX_W'(level_r - 1'b1)];
                level_nxt = level_r - 1'b1;
              end
            end
            default: ;
          endcase
        end
        TYPE_LOCAL: begin
          if (ex_tag == L_USAGE) begin
            if (ex_nb == 3'd4) begin
              ulist_wd = ex_v;
              if (ex_v[31:16] == PAGE_DIGI) digi_nxt = 1'b1;
            end else begin
              ulist_wd = {glob_r.page, ex_v[15:0]};
            end
            if (32'(ucnt_r) < 32'(LOCAL_USAGE_DEPTH)) begin
              ulist_we = 1'b1;
              ucnt_nxt = ucnt_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (ex_tag == L_UMIN) begin
            rlo_nxt   = ex_v;
            rflag_nxt = 1'b1;
          end else if (ex_tag == L_UMAX) begin
            rhi_nxt   = ex_v;
            rflag_nxt = 1'b1;
          end
        end
        TYPE_MAIN: begin
          if (ex_tag == M_INPUT && glob_r.rsize != '0 && glob_r.rcount != '0) begin
            // locals stay until the walk is over
            start_walk = 1'b1;
            const_nxt  = ex_v[0];
            ci_nxt     = raddr;
            idx_nxt    = '0;
            made_nxt   = '0;
            pendv_nxt  = 1'b0;
          end else begin
            ucnt_nxt  = '0;
            rlo_nxt   = '0;
            rhi_nxt   = '0;
            rflag_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end

    // cursor fetch
    if (state_r == S_LOAD) begin
      cur_nxt = rd_q;
    end

    // one report count element per cycle while the output does not stall the walk
    if (walk_adv) begin
      if (w_emit) begin
        if (pendv_r) begin
          outv_nxt = 1'b1;
          out_nxt  = pend_r;
        end
        pend_nxt  = w_rec;
        pendv_nxt = 1'b1;
        made_nxt  = made_r + 1'b1;
      end
      if (w_hit) begin
        if (!w_emit) ovf_nxt = 1'b1;
        axes_nxt = axes_nxt | axis_bit(w_slot);
        if (w_slot == SLOT_INVERT) inv_nxt = 1'b1;
        if (w_slot == SLOT_SERIAL) ser_nxt = 1'b1;
      end
      cur_nxt = cur_step;
      idx_nxt = idx_r + 16'd1;
      if (walk_last) begin
        cwr.en    = 1'b1;
        cwr.addr  = ci_r;
        cwr.data  = cur_step;
        ucnt_nxt  = '0;
        rlo_nxt   = '0;
        rhi_nxt   = '0;
        rflag_nxt = 1'b0;
      end
    end

    // hand over the held record
    if (flush_done && pendv_r) begin
      outv_nxt = 1'b1;
      out_nxt  = pend_r;
      out_nxt.last_of_run = !endp_r;
      pendv_nxt = 1'b0;
    end

    // end summary
    if (sum_done) begin
      outv_nxt = 1'b1;
      out_nxt  = sum_rec;
    end

    // clearing pass over the cursor memory
    if (state_r == S_CLEAR) begin
      cwr.en   = 1'b1;
      cwr.addr = clr_r;
      cwr.data = '0;
      clr_nxt  = clr_r + 1'b1;
    end
  end

  // stack and usage list storage
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[level_r[SK_IDX_W-1:0]] <= glob_r;
    end
    if (ulist_we) begin
      ulist_mem[ucnt_r[LU_IDX_W-1:0]] <= ulist_wd;
    end
  end

  // output and walk payload registers
  always_ff @(posedge clk) begin
    out_r    <= out_nxt;
    pend_r   <= pend_nxt;
    prefix_r <= prefix_nxt;
    accum_r  <= accum_nxt;
    const_r  <= const_nxt;
    idx_r    <= idx_nxt;
    cur_r    <= cur_nxt;
    ci_r     <= ci_nxt;
  end

  // control and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= soft_clr ? '0 : clr_nxt;
      outv_r  <= outv_nxt;
    end
    if (!rst_n || soft_clr) begin
      phase_r <= PH_PREFIX;
      left_r  <= '0;
      skip_r  <= '0;
      glob_r  <= '0;
      level_r <= '0;
      ucnt_r  <= '0;
      rlo_r   <= '0;
      rhi_r   <= '0;
      rflag_r <= 1'b0;
      axes_r  <= '0;
      ids_r   <= 1'b0;
      inv_r   <= 1'b0;
      ser_r   <= 1'b0;
      digi_r  <= 1'b0;
      ovf_r   <= 1'b0;
      endp_r  <= 1'b0;
      made_r  <= '0;
      pendv_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      skip_r  <= skip_nxt;
      glob_r  <= glob_nxt;
      level_r <= level_nxt;
      ucnt_r  <= ucnt_nxt;
      rlo_r   <= rlo_nxt;
      rhi_r   <= rhi_nxt;
      rflag_r <= rflag_nxt;
      axes_r  <= axes_nxt;
      ids_r   <= ids_nxt;
      inv_r   <= inv_nxt;
      ser_r   <= ser_nxt;
      digi_r  <= digi_nxt;
      ovf_r   <= ovf_nxt;
      endp_r  <= endp_nxt;
      made_r  <= made_nxt;
      pendv_r <= pendv_nxt;
    end
  end

endmodule

/* bench/hid_report_descriptor_parser_top_tb.sv */
module hid_report_descriptor_parser_top_tb;
  import hidrd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] page;
    logic signed [31:0] lmin;
    logic signed [32:0] lmax;
    logic [7:0] rsize;
    logic [15:0] rcount;
    logic [7:0] rid;
  } glob_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  out_t record_fifo[$];
  int fail_cnt = 0;
  bit idle_en = 1'b1;

  // parser shadow state
  logic [1:0] ph;
  logic [7:0] pfx;
  logic [31:0] acc;
  int pleft;
  int skip_left;
  glob_t gl;
  glob_t gstk[STACK_DEPTH];
  int slev;
  logic [31:0] ulist[LOCAL_USAGE_DEPTH];
  int ucnt;
  logic [31:0] rlo, rhi;
  bit rflag;
  logic [19:0] cursors[REPORT_ID_COUNT];
  logic [5:0] s_axes;
  bit s_ids, s_inv, s_ser, s_digi, s_ovf;

  hid_report_descriptor_parser_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void shadow_reset();
    ph = PH_PREFIX; pfx = '0; acc = '0; pleft = 0; skip_left = 0;
    gl = '{default: '0}; slev = 0; ucnt = 0; rlo = '0; rhi = '0; rflag = 0;
    foreach (cursors[i]) cursors[i] = '0;
    s_axes = '0; {s_ids, s_inv, s_ser, s_digi, s_ovf} = '0;
  endfunction

  function automatic logic signed [31:0] sext(logic [31:0] v, int nb);
    if (nb == 1) return {{24{v[7]}}, v[7:0]};
    if (nb == 2) return {{16{v[15]}}, v[15:0]};
    return v;
  endfunction

  // field walk of one input main item
  function automatic void walk_input(logic [31:0] fl);
    int ci;
    logic [20:0] cur;
    int made;
    logic [15:0] page, usage;
    logic [4:0] slot;
    logic [32:0] u;
    out_t r;
    ci = gl.rid;
    cur = {1'b0, cursors[ci]};
    made = 0;
    for (int idx = 0; idx < gl.rcount; idx++) begin
      page = gl.page; usage = '0; slot = SLOT_NONE;
      if (!fl[0]) begin
        if (ucnt > 0) begin
          {page, usage} = ulist[(idx < ucnt) ? idx : ucnt - 1];
        end else if (rflag) begin
          u = {1'b0, rlo} + 33'(idx);
          if (u > {1'b0, rhi}) u = {1'b0, rhi};
          usage = u[15:0];
        end
        case (page)
          16'h0001:
            case (usage)
              16'h30: slot = SLOT_X;
              16'h31: slot = SLOT_Y;
              16'h32: slot = SLOT_DISTANCE;
              16'h38: slot = SLOT_WHEEL;
              default: slot = SLOT_NONE;
            endcase
          16'h000D:
            case (usage)
              16'h30: slot = SLOT_PRESSURE;
              16'h31: slot = SLOT_SLIDER;
              16'h3D: slot = SLOT_TILT_X;
              16'h3E: slot = SLOT_TILT_Y;
              16'h41: slot = SLOT_ROTATION;
              16'h32: slot = SLOT_INRANGE;
              16'h42: slot = SLOT_TIP;
              16'h3C: slot = SLOT_INVERT;
              16'h44: slot = SLOT_BARREL;
              16'h5A: slot = SLOT_BARREL2;
              16'h45: slot = SLOT_ERASER;
              16'h5B: slot = SLOT_SERIAL;
              default: slot = SLOT_NONE;
            endcase
          default: slot = SLOT_NONE;
        endcase
      end
      if (slot != SLOT_NONE) begin
        if (made < FIELDS_PER_MAIN) begin
          r = '0;
          r.field_report_id = gl.rid; r.field_page = page; r.field_usage = usage;
          r.bit_pos = cur[19:0]; r.field_width = gl.rsize;
          r.range_min = gl.lmin; r.range_max = gl.lmax; r.slot_code = slot[3:0];
          record_fifo.insert(record_fifo.size(), r);
          made++;
        end else begin
          s_ovf = 1;
        end
        case (slot)
          SLOT_PRESSURE: s_axes |= 6'h01;
          SLOT_DISTANCE: s_axes |= 6'h02;
          SLOT_TILT_X, SLOT_TILT_Y: s_axes |= 6'h04;
          SLOT_ROTATION: s_axes |= 6'h08;
          SLOT_SLIDER: s_axes |= 6'h10;
          SLOT_WHEEL: s_axes |= 6'h20;
          SLOT_INVERT: s_inv = 1;
          SLOT_SERIAL: s_ser = 1;
          default: ;
        endcase
      end
      cur = cur + 21'(gl.rsize);
      if (cur > {1'b0, CURSOR_MAX}) cur = {1'b0, CURSOR_MAX};
    end
    cursors[ci] = cur[19:0];
  endfunction

  function automatic void run_item(logic [7:0] p, logic [31:0] v, int nb);
    logic [1:0] ty;
    logic [3:0] tg;
    logic signed [31:0] s;
    ty = p[3:2];
    tg = p[7:4];
    if (ty == TYPE_GLOBAL) begin
      case (tg)
        G_PAGE: begin
          gl.page = v[15:0];
          if (gl.page == PAGE_DIGI) s_digi = 1;
        end
        G_LMIN: gl.lmin = sext(v, nb);
        G_LMAX: begin
          s = sext(v, nb);
          gl.lmax = (gl.lmin >= 0 && s < 0) ? $signed({1'b0, v}) : 33'(s);
        end
        G_RSIZE: gl.rsize = (v > 255) ? 8'hFF : v[7:0];
        G_RID: begin
          gl.rid = v[7:0]; s_ids = 1;
        end
        G_RCOUNT: gl.rcount = (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
        G_PUSH: begin
          if (slev < STACK_DEPTH) gstk[slev++] = gl;
          else s_ovf = 1;
        end
        G_POP: if (slev > 0) gl = gstk[--slev];
        default: ;
      endcase
      return;
    end
    if (ty == TYPE_LOCAL) begin
      if (tg == L_USAGE) begin
        if (nb == 4 && v[31:16] == PAGE_DIGI) s_digi = 1;
        if (ucnt < LOCAL_USAGE_DEPTH) ulist[ucnt++] = (nb == 4) ? v : {gl.page, v[15:0]};
        else s_ovf = 1;
      end else if (tg == L_UMIN) begin
        rlo = v; rflag = 1;
      end else if (tg == L_UMAX) begin
        rhi = v; rflag = 1;
      end
      return;
    end
    if (ty != TYPE_MAIN) return;
    if (tg == M_INPUT && gl.rsize != 0 && gl.rcount != 0) walk_input(v);
    ucnt = 0; rlo = '0; rhi = '0; rflag = 0;
  endfunction

  // predict the records one descriptor byte causes
  function automatic void predict_byte(logic [7:0] b, logic last);
    int base, tot;
    out_t r;
    base = record_fifo.size();
    case (ph)
      PH_PREFIX: begin
        if (b == LONG_PREFIX) ph = PH_LONG_SIZE;
        else begin
          tot = (b[1:0] == 2'd3) ? 4 : b[1:0];
          if (tot == 0) run_item(b, '0, 0);
          else begin
            pfx = b; acc = '0; pleft = tot; ph = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        tot = (pfx[1:0] == 2'd3) ? 4 : pfx[1:0];
        acc |= 32'(b) << (8 * ((tot - pleft) & 3));
        pleft--;
        if (pleft == 0) begin
          ph = PH_PREFIX;
          run_item(pfx, acc, tot);
        end
      end
      PH_LONG_SIZE: begin
        skip_left = b + 1; ph = PH_LONG_SKIP;
      end
      default: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) ph = PH_PREFIX;
      end
    endcase
    if (last) begin
      r = '0;
      r.record_kind = 1'b1;
      r.axes_mask = s_axes;
      r.status_flags = {s_ovf, s_digi, s_ser, s_inv, s_ids};
      record_fifo.insert(record_fifo.size(), r);
      shadow_reset();
    end
    if (record_fifo.size() > base) record_fifo[$].last_of_run = 1'b1;
  endfunction

  // send one byte transaction; valid stays up for a directly following byte
  task automatic send_byte(logic [7:0] b, logic last = 1'b0);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{desc_byte: b, end_of_descriptor: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, last);
    @(negedge clk);
  endtask

  task automatic short_item(logic [3:0] tg, logic [1:0] ty, logic [31:0] v, int nb);
    logic [1:0] sz;
    sz = (nb == 4) ? 2'd3 : nb[1:0];
    send_byte({tg, ty, sz});
    for (int i = 0; i < nb; i++) send_byte(v[8 * i +: 8]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (record_fifo.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // record checker
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (record_fifo.size() == 0) begin
        $error("unexpected record %h", out_data);
        fail_cnt++;
      end else begin
        e = record_fifo.pop_front();
        if (out_data.record_kind !== e.record_kind) begin
          $error("record_kind exp %h got %h", e.record_kind, out_data.record_kind); fail_cnt++;
        end
        if (out_data.field_report_id !== e.field_report_id) begin
          $error("field_report_id exp %h got %h", e.field_report_id,
            out_data.field_report_id); fail_cnt++;
        end
        if (out_data.field_page !== e.field_page) begin
          $error("field_page exp %h got %h", e.field_page, out_data.field_page); fail_cnt++;
        end
        if (out_data.field_usage !== e.field_usage) begin
          $error("field_usage exp %h got %h", e.field_usage, out_data.field_usage); fail_cnt++;
        end
        if (out_data.bit_pos !== e.bit_pos) begin
          $error("bit_pos exp %h got %h", e.bit_pos, out_data.bit_pos); fail_cnt++;
        end
        if (out_data.field_width !== e.field_width) begin
          $error("field_width exp %h got %h", e.field_width, out_data.field_width); fail_cnt++;
        end
        if (out_data.range_min !== e.range_min) begin
          $error("range_min exp %h got %h", e.range_min, out_data.range_min); fail_cnt++;
        end
        if (out_data.range_max !== e.range_max) begin
          $error("range_max exp %h got %h", e.range_max, out_data.range_max); fail_cnt++;
        end
        if (out_data.slot_code !== e.slot_code) begin
          $error("slot_code exp %h got %h", e.slot_code, out_data.slot_code); fail_cnt++;
        end
        if (out_data.axes_mask !== e.axes_mask) begin
          $error("axes_mask exp %h got %h", e.axes_mask, out_data.axes_mask); fail_cnt++;
        end
        if (out_data.status_flags !== e.status_flags) begin
          $error("status_flags exp %h got %h", e.status_flags, out_data.status_flags);
          fail_cnt++;
        end
        if (out_data.last_of_run !== e.last_of_run) begin
          $error("last_of_run exp %h got %h", e.last_of_run, out_data.last_of_run); fail_cnt++;
        end
      end
    end
  end

  // receiver stall bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // pen descriptor with ids, push/pop, ranges, long item and saturation
  task automatic test_directed();
    short_item(G_PAGE, TYPE_GLOBAL, 32'h0D, 1);
    short_item(G_RID, TYPE_GLOBAL, 32'hFF, 1);
    short_item(G_LMIN, TYPE_GLOBAL, 32'h00, 1);
    short_item(G_LMAX, TYPE_GLOBAL, 32'hFFFF, 2);
    short_item(G_RSIZE, TYPE_GLOBAL, 32'h1FF, 2);
    short_item(G_RCOUNT, TYPE_GLOBAL, 32'h3, 1);
    short_item(L_USAGE, TYPE_LOCAL, 32'h30, 1);
    short_item(L_USAGE, TYPE_LOCAL, 32'h0001_0030, 4);
    short_item(L_USAGE, TYPE_LOCAL, 32'h5B, 1);
    short_item(M_INPUT, TYPE_MAIN, 32'h2, 1);
    send_byte(LONG_PREFIX); send_byte(8'd2); send_byte(8'h11);
    send_byte(8'hAA); send_byte(8'h55);
    short_item(G_PUSH, TYPE_GLOBAL, 0, 0);
    short_item(G_LMIN, TYPE_GLOBAL, 32'h80, 1);
    short_item(G_LMAX, TYPE_GLOBAL, 32'h8000_0000, 4);
    short_item(L_UMIN, TYPE_LOCAL, 32'h3C, 1);
    short_item(L_UMAX, TYPE_LOCAL, 32'h3E, 1);
    short_item(G_RCOUNT, TYPE_GLOBAL, 32'h1_0000, 4);
    short_item(G_RSIZE, TYPE_GLOBAL, 32'h10, 1);
    short_item(M_INPUT, TYPE_MAIN, 32'h0, 0);
    short_item(G_POP, TYPE_GLOBAL, 0, 0);
    for (int i = 0; i < 6; i++) short_item(G_PUSH, TYPE_GLOBAL, 0, 0);
    short_item(M_INPUT, TYPE_MAIN, 32'h1, 1);
    for (int i = 0; i < 7; i++) short_item(G_POP, TYPE_GLOBAL, 0, 0);
    for (int i = 0; i < 18; i++) short_item(L_USAGE, TYPE_LOCAL, 32'h42, 1);
    send_byte(8'hFC);
    short_item(M_INPUT, TYPE_MAIN, 32'h0, 1);
    send_byte(8'h81, 1'b1);
  endtask

  // empty descriptor: summary only; then one ending inside a payload
  task automatic test_edges();
    send_byte(8'h00, 1'b1);
    send_byte(8'h05);
    send_byte(8'h0D, 1'b1);
  endtask

  // random descriptors of mostly well-formed items
  task automatic test_random(int n_items);
    logic [3:0] tg;
    logic [1:0] ty;
    int nb, k;
    logic [31:0] v;
    logic [3:0] gtags[8] = '{G_PAGE, G_LMIN, G_LMAX, G_RSIZE, G_RID, G_RCOUNT,
                             G_PUSH, G_POP};
    for (int i = 0; i < n_items; i++) begin
      k = $urandom_range(0, 99);
      nb = $urandom_range(0, 3);
      if (nb == 3) nb = 4;
      v = $urandom;
      if (k < 35) begin
        ty = TYPE_GLOBAL; tg = gtags[$urandom_range(0, 7)];
        if (tg == G_PAGE && $urandom_range(0, 2) != 0) begin
          v = $urandom_range(0, 1) ? 32'h0D : 32'h01; nb = 1;
        end
        if (tg == G_RCOUNT && $urandom_range(0, 3) != 0) begin
          v = $urandom_range(0, 12); nb = 1;
        end
        if (tg == G_RSIZE && $urandom_range(0, 3) != 0) begin
          v = $urandom_range(0, 32); nb = 1;
        end
      end else if (k < 70) begin
        ty = TYPE_LOCAL; tg = 4'($urandom_range(0, 3));
        if ($urandom_range(0, 2) != 0) begin
          v = {$urandom_range(0, 1) ? 16'h0D : 16'h01, 16'($urandom_range(16'h30, 16'h5B))};
        end
      end else if (k < 90) begin
        ty = TYPE_MAIN; tg = $urandom_range(0, 1) ? M_INPUT : 4'($urandom);
      end else if (k < 95) begin
        ty = 2'd3; tg = 4'($urandom);
      end else begin
        send_byte(8'($urandom));
        continue;
      end
      if (tg == G_PUSH && ty == TYPE_GLOBAL) nb = 0;
      short_item(tg, ty, v, nb);
      if ($urandom_range(0, 29) == 0) send_byte(8'($urandom), 1'b1);
    end
    send_byte(8'h00, 1'b1);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_edges();
    // sender holds off until the queue is empty
    wait_drained();
    test_random(9);
    idle_en = 1'b0;
    test_random(4);
    wait_drained();
    if (fail_cnt == 0 && record_fifo.size() == 0) begin
      $display("hid_report_descriptor_parser_top regression: pass");
    end else begin
      $display("hid_report_descriptor_parser_top regression: fail");
    end
    $finish;
  end

  initial begin
    #500ms;
    $display("hid_report_descriptor_parser_top regression: fail");
    $finish;
  end

endmodule
